// ===== design/wso_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wso_pkg
// Shared types and constants for the wavetable sine oscillator.
// ----------------------------------------------------------------------------
package wso_pkg;

    // field and state widths
    localparam int INC_W      = 26;   // target increment, 10.16
    localparam int AMP_W      = 16;   // target gain, Q2.14
    localparam int SMP_W      = 16;   // output sample, Q1.15
    localparam int RS_W       = 16;   // ramp length register
    localparam int INC_EXTRA  = 6;    // extra fraction bits of smoothed increment
    localparam int GAIN_EXTRA = 8;    // extra fraction bits of smoothed gain
    localparam int INOW_W     = INC_W + INC_EXTRA;   // 32
    localparam int GNOW_W     = AMP_W + GAIN_EXTRA;  // 24

    localparam logic [RS_W-1:0] RAMP_RESET = 16'd4800;
    localparam int TABLE_SIZE_DEF = 1024;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_STEP,
        ST_PHASE,
        ST_RDA,
        ST_RDB,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
        logic phase;
        logic rd_next;
        logic cap_a;
        logic mul1;
        logic mul2;
        logic mul3;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
    } t_sts;

endpackage
`default_nettype wire

// ===== design/wso_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wso_div
// Radix-2 restoring divider: unsigned W-bit dividend by 16-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wso_div
    import wso_pkg::*;
#(
    parameter int W = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [W-1:0]    i_dividend,
    input  wire logic [RS_W-1:0] i_divisor,
    output logic                 o_busy,
    output logic [W-1:0]         o_quotient
);

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic [W-1:0]    r_quo;
    logic [RS_W-1:0] r_rem;
    logic [RS_W-1:0] r_div;
    logic [RS_W:0]   rem_sh;
    logic [RS_W:0]   rem_sub;
    logic            ge;

    // one trial subtract per cycle
    always_comb begin
        rem_sh  = {r_rem, r_quo[W-1]};
        ge      = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // quotient / remainder shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], ge};
            r_rem <= ge ? rem_sub[RS_W-1:0] : rem_sh[RS_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== design/wso_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wso_ctrl
// Sequencer for one tick: ramp division, smoother step, phase advance,
// two ROM reads, interpolation and gain multiply, output register load.
// ----------------------------------------------------------------------------
module wso_ctrl
    import wso_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_DIV;
            ST_DIV:   if (!i_sts.div_busy) n_state = ST_STEP;
            ST_STEP:  n_state = ST_PHASE;
            ST_PHASE: n_state = ST_RDA;
            ST_RDA:   n_state = ST_RDB;
            ST_RDB:   n_state = ST_MUL1;
            ST_MUL1:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_MUL3;
            ST_MUL3:  n_state = ST_OUT;
            ST_OUT:   if (slot_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:  o_cmd.accept   = i_in_valid;
            ST_STEP:  o_cmd.step     = 1'b1;
            ST_PHASE: o_cmd.phase    = 1'b1;
            ST_RDB: begin
                o_cmd.cap_a   = 1'b1;
                o_cmd.rd_next = 1'b1;
            end
            ST_MUL1:  o_cmd.mul1     = 1'b1;
            ST_MUL2:  o_cmd.mul2     = 1'b1;
            ST_MUL3:  o_cmd.mul3     = 1'b1;
            ST_OUT:   o_cmd.load_out = slot_free;
            default:  o_cmd = '0;
        endcase
    end

    // output beat valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== design/wso_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wso_dp
// Datapath: ramp smoothers with serial step dividers, phase accumulator,
// sine ROM, interpolation and gain multiply with round and saturate.
// ----------------------------------------------------------------------------
module wso_dp
    import wso_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF  // power of two
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic [INC_W-1:0]  i_target_increment,
    input  wire logic [AMP_W-1:0]  i_target_amplitude,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [RS_W-1:0]   i_cfg_wr_data,
    output logic [SMP_W-1:0]       o_output_sample
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int PW = AW + 16;
    localparam int SW = (PW > INC_W) ? PW : INC_W;

    typedef logic [TABLE_SIZE-1:0][15:0] t_rom_img;

    // one sine cycle, Q30 Taylor series over the first quadrant
    function automatic t_rom_img build_rom();
        t_rom_img        img;
        longint unsigned t;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned s;
        logic            neg;
        img = '0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            t   = (64'(i) << 32) / TABLE_SIZE;
            neg = 1'b0;
            if (t >= 64'h8000_0000) begin
                neg = 1'b1;
                t   = t - 64'h8000_0000;
            end
            if (t > 64'h4000_0000) begin
                t = 64'h8000_0000 - t;
            end
            x    = (t * 64'd1686629713) >> 30;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int k = 1; k <= 8; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            s = (sum * 64'd32767 + 64'h2000_0000) >> 30;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            img[i] = neg ? 16'(-s) : 16'(s);
        end
        return img;
    endfunction

    localparam t_rom_img C_ROM = build_rom();

    // architectural state
    logic [RS_W-1:0]   r_ramp_steps;
    logic [INOW_W-1:0] r_inc_now;
    logic [INC_W-1:0]  r_inc_goal;
    logic [INOW_W:0]   r_inc_step;
    logic [RS_W-1:0]   r_inc_left;
    logic [GNOW_W-1:0] r_gain_now;
    logic [AMP_W-1:0]  r_gain_goal;
    logic [GNOW_W:0]   r_gain_step;
    logic [RS_W-1:0]   r_gain_left;
    logic [PW-1:0]     r_phase;

    // per-tick payload
    logic [INC_W-1:0]  r_tgt_inc;
    logic [AMP_W-1:0]  r_tgt_amp;
    logic              r_inc_neg;
    logic              r_gain_neg;
    logic signed [15:0] r_rom_q;
    logic signed [15:0] r_a;
    logic signed [33:0] r_dprod;
    logic signed [33:0] r_interp;
    logic signed [50:0] r_prod;
    logic [SMP_W-1:0]  r_out;

    // ramp deltas at accept
    logic signed [INOW_W:0] inc_diff;
    logic [INOW_W:0]        inc_mag;
    logic signed [GNOW_W:0] gain_diff;
    logic [GNOW_W:0]        gain_mag;
    logic [INOW_W-1:0]      inc_quo;
    logic [GNOW_W-1:0]      gain_quo;
    logic                   inc_busy;
    logic                   gain_busy;

    always_comb begin
        inc_diff  = $signed({1'b0, i_target_increment, {INC_EXTRA{1'b0}}})
                  - $signed({1'b0, r_inc_now});
        inc_mag   = inc_diff[INOW_W] ? (INOW_W+1)'(-inc_diff) : inc_diff;
        gain_diff = $signed({1'b0, i_target_amplitude, {GAIN_EXTRA{1'b0}}})
                  - $signed({1'b0, r_gain_now});
        gain_mag  = gain_diff[GNOW_W] ? (GNOW_W+1)'(-gain_diff) : gain_diff;
    end

    wso_div #(.W(INOW_W)) u_div_inc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.accept),
        .i_dividend (inc_mag[INOW_W-1:0]),
        .i_divisor  (r_ramp_steps),
        .o_busy     (inc_busy),
        .o_quotient (inc_quo)
    );

    wso_div #(.W(GNOW_W)) u_div_gain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.accept),
        .i_dividend (gain_mag[GNOW_W-1:0]),
        .i_divisor  (r_ramp_steps),
        .o_busy     (gain_busy),
        .o_quotient (gain_quo)
    );

    assign o_sts.div_busy = inc_busy || gain_busy;

    // smoother: apply target, then step
    logic [INC_W-1:0]  inc_goal_s;
    logic [INOW_W-1:0] inc_now_s;
    logic [INOW_W:0]   inc_step_s;
    logic [RS_W-1:0]   inc_left_s;
    logic [INOW_W-1:0] n_inc_now;
    logic [RS_W-1:0]   n_inc_left;
    logic [INOW_W:0]   inc_sum;
    logic [AMP_W-1:0]  gain_goal_s;
    logic [GNOW_W-1:0] gain_now_s;
    logic [GNOW_W:0]   gain_step_s;
    logic [RS_W-1:0]   gain_left_s;
    logic [GNOW_W-1:0] n_gain_now;
    logic [RS_W-1:0]   n_gain_left;
    logic [GNOW_W:0]   gain_sum;

    always_comb begin
        inc_goal_s = r_inc_goal;
        inc_now_s  = r_inc_now;
        inc_step_s = r_inc_step;
        inc_left_s = r_inc_left;
        if (r_tgt_inc != r_inc_goal) begin
            inc_goal_s = r_tgt_inc;
            if (r_ramp_steps == '0) begin
                inc_now_s  = {r_tgt_inc, {INC_EXTRA{1'b0}}};
                inc_step_s = '0;
                inc_left_s = '0;
            end else begin
                inc_step_s = r_inc_neg ? (INOW_W+1)'(-{1'b0, inc_quo}) : {1'b0, inc_quo};
                inc_left_s = r_ramp_steps;
            end
        end
        inc_sum    = {1'b0, inc_now_s} + inc_step_s;
        n_inc_left = '0;
        n_inc_now  = {inc_goal_s, {INC_EXTRA{1'b0}}};
        if (inc_left_s != '0) begin
            n_inc_left = inc_left_s - 1'b1;
            if (n_inc_left != '0) begin
                n_inc_now = inc_sum[INOW_W-1:0];
            end
        end

        gain_goal_s = r_gain_goal;
        gain_now_s  = r_gain_now;
        gain_step_s = r_gain_step;
        gain_left_s = r_gain_left;
        if (r_tgt_amp != r_gain_goal) begin
            gain_goal_s = r_tgt_amp;
            if (r_ramp_steps == '0) begin
                gain_now_s  = {r_tgt_amp, {GAIN_EXTRA{1'b0}}};
                gain_step_s = '0;
                gain_left_s = '0;
            end else begin
                gain_step_s = r_gain_neg ? (GNOW_W+1)'(-{1'b0, gain_quo})
                                         : {1'b0, gain_quo};
                gain_left_s = r_ramp_steps;
            end
        end
        gain_sum    = {1'b0, gain_now_s} + gain_step_s;
        n_gain_left = '0;
        n_gain_now  = {gain_goal_s, {GAIN_EXTRA{1'b0}}};
        if (gain_left_s != '0) begin
            n_gain_left = gain_left_s - 1'b1;
            if (n_gain_left != '0) begin
                n_gain_now = gain_sum[GNOW_W-1:0];
            end
        end
    end

    // phase accumulator, wraps at the table length
    logic [SW-1:0] phase_sum;
    assign phase_sum = SW'(r_phase) + SW'(r_inc_now[INOW_W-1:INC_EXTRA]);

    // smoother and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_steps <= RAMP_RESET;
            r_inc_now    <= '0;
            r_inc_goal   <= '0;
            r_inc_step   <= '0;
            r_inc_left   <= '0;
            r_gain_now   <= '0;
            r_gain_goal  <= '0;
            r_gain_step  <= '0;
            r_gain_left  <= '0;
            r_phase      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                // snap both smoothers to their goals
                r_ramp_steps <= i_cfg_wr_data;
                r_inc_now    <= {r_inc_goal, {INC_EXTRA{1'b0}}};
                r_inc_step   <= '0;
                r_inc_left   <= '0;
                r_gain_now   <= {r_gain_goal, {GAIN_EXTRA{1'b0}}};
                r_gain_step  <= '0;
                r_gain_left  <= '0;
            end else if (i_cmd.step) begin
                r_inc_goal   <= inc_goal_s;
                r_inc_step   <= inc_step_s;
                r_inc_now    <= n_inc_now;
                r_inc_left   <= n_inc_left;
                r_gain_goal  <= gain_goal_s;
                r_gain_step  <= gain_step_s;
                r_gain_now   <= n_gain_now;
                r_gain_left  <= n_gain_left;
            end
            if (i_cmd.phase) begin
                r_phase <= phase_sum[PW-1:0];
            end
        end
    end

    // beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tgt_inc  <= i_target_increment;
            r_tgt_amp  <= i_target_amplitude;
            r_inc_neg  <= inc_diff[INOW_W];
            r_gain_neg <= gain_diff[GNOW_W];
        end
    end

    // sine ROM, registered read
    logic [AW-1:0] idx;
    logic [AW-1:0] rd_addr;
    assign idx     = r_phase[PW-1:16];
    assign rd_addr = i_cmd.rd_next ? idx + 1'b1 : idx;

    always_ff @(posedge i_clk) begin
        r_rom_q <= C_ROM[rd_addr];
    end

    // interpolation and gain
    logic signed [16:0] slope;
    assign slope = 17'(r_rom_q) - 17'(r_a);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_a) begin
            r_a <= r_rom_q;
        end
        if (i_cmd.mul1) begin
            r_dprod <= slope * $signed({1'b0, r_phase[15:0]});
        end
        if (i_cmd.mul2) begin
            r_interp <= (34'(r_a) <<< 16) + r_dprod;
        end
        if (i_cmd.mul3) begin
            r_prod <= r_interp * $signed({1'b0, r_gain_now[GNOW_W-1:GAIN_EXTRA]});
        end
    end

    // round half up, saturate to 16 bits
    logic signed [50:0] rsum;
    logic signed [20:0] rnd;
    logic [SMP_W-1:0]   sat;
    always_comb begin
        rsum = r_prod + 51'sd536870912;
        rnd  = rsum[50:30];
        if (rnd > 21'sd32767) begin
            sat = 16'h7FFF;
        end else if (rnd < -21'sd32768) begin
            sat = 16'h8000;
        end else begin
            sat = rnd[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= sat;
        end
    end

    assign o_output_sample = r_out;

endmodule
`default_nettype wire

// ===== design/wavetable_sine_oscillator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wavetable_sine_oscillator
// The serial ramp-step dividers set most of the time from input beat to output beat
// valid, then 8 sequencer steps follow.
// One tick is in flight at a time, and a finished sample waits in the output register.
// Reset (synchronous, active low): smoothers and phase to zero, ramp_steps 4800.
// ----------------------------------------------------------------------------
module wavetable_sine_oscillator
    import wso_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [INC_W-1:0] i_target_increment,
    input  wire logic [AMP_W-1:0] i_target_amplitude,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [SMP_W-1:0]      o_output_sample,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [RS_W-1:0]  i_cfg_wr_data
);

    t_cmd cmd;
    t_sts sts;

    wso_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    wso_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_target_increment (i_target_increment),
        .i_target_amplitude (i_target_amplitude),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .o_output_sample    (o_output_sample)
    );

    // a taken beat closes the input until the tick is done
    a_in_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready stayed high after a beat");

    // accept starts both dividers
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> sts.div_busy)
        else $error("dividers not started on accept");

    // smoother update only with finished quotients
    a_step_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !sts.div_busy)
        else $error("smoother stepped while divider busy");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wavetable sine oscillator. Ticks go in through
// a valid/ready driver with random idle bursts; samples are checked against
// a bit-exact predictor of ramp smoothers, phase accumulator, sine table
// interpolation and gain product. Several ramp lengths are used, extremes too.
// ----------------------------------------------------------------------------
module tb_top;
    import wso_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TSIZE = TABLE_SIZE_DEF;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [INC_W-1:0] inc;
        logic [AMP_W-1:0] amp;
    } t_tick;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [INC_W-1:0] i_target_increment = '0;
    logic [AMP_W-1:0] i_target_amplitude = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [SMP_W-1:0] o_output_sample;
    logic i_cfg_wr_en = 1'b0;
    logic [RS_W-1:0] i_cfg_wr_data = '0;

    wavetable_sine_oscillator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_target_increment(i_target_increment),
        .i_target_amplitude(i_target_amplitude),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_output_sample(o_output_sample),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // predictor state
    logic signed [15:0] sine_tab [TSIZE];
    longint unsigned phase_acc, inc_now, inc_goal, gain_now, gain_goal;
    longint inc_step, gain_step;
    int unsigned inc_left, gain_left, ramp_len;

    t_tick tick_q[$];
    logic [SMP_W-1:0] sample_q[$];
    int err_cnt = 0;
    bit calm = 1'b0;
    int unsigned quiet = 0;

    task automatic report(input string what);
        err_cnt++;
        $display("mismatch: %s", what);
    endtask

    // integer Taylor series for one table entry
    function automatic logic signed [15:0] sine_point(input longint unsigned i);
        longint unsigned t, x, x2, term, sum, s;
        bit neg;
        t = (i << 32) / TSIZE;
        neg = 1'b0;
        if (t >= (64'd1 << 31)) begin
            neg = 1'b1;
            t -= (64'd1 << 31);
        end
        if (t > (64'd1 << 30)) t = (64'd1 << 31) - t;
        x = (t * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k & 1) sum -= term;
            else sum += term;
        end
        s = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (s > 32767) s = 32767;
        return neg ? -$signed(s[15:0]) : $signed(s[15:0]);
    endfunction

    function automatic void retarget(input longint unsigned target, input int extra,
                                     ref longint unsigned now,
                                     ref longint unsigned goal,
                                     ref longint step, ref int unsigned left);
        if (target == goal) return;
        goal = target;
        if (ramp_len == 0) begin
            now = target << extra;
            left = 0;
            step = 0;
        end else begin
            left = ramp_len;
            step = (longint'(target << extra) - longint'(now)) / longint'(ramp_len);
        end
    endfunction

    function automatic void ramp_tick(input int extra, ref longint unsigned now,
                                      input longint unsigned goal, input longint step,
                                      ref int unsigned left);
        if (left == 0) begin
            now = goal << extra;
        end else begin
            left--;
            if (left > 0) now = longint'(now) + step;
            else now = goal << extra;
        end
    endfunction

    function automatic logic [SMP_W-1:0] next_sample(input t_tick t);
        longint unsigned idx, frac, g, biased;
        longint a, b, interp, prod, v;
        retarget(t.inc, INC_EXTRA, inc_now, inc_goal, inc_step, inc_left);
        retarget(t.amp, GAIN_EXTRA, gain_now, gain_goal, gain_step, gain_left);
        ramp_tick(INC_EXTRA, inc_now, inc_goal, inc_step, inc_left);
        phase_acc = (phase_acc + (inc_now >> INC_EXTRA)) % (longint'(TSIZE) << 16);
        idx = phase_acc >> 16;
        frac = phase_acc & 16'hFFFF;
        a = sine_tab[idx % TSIZE];
        b = sine_tab[(idx + 1) % TSIZE];
        interp = a * 65536 + (b - a) * longint'(frac);
        ramp_tick(GAIN_EXTRA, gain_now, gain_goal, gain_step, gain_left);
        g = gain_now >> GAIN_EXTRA;
        prod = interp * longint'(g);
        biased = prod + (64'sd1 << 29) + (64'sd1 << 50);
        v = longint'(biased >> 30) - (64'sd1 << 20);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // driver: one tick beat at a time, random idle bursts
    int unsigned in_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sample_q.push_back(next_sample({i_target_increment, i_target_amplitude}));
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (tick_q.size() > 0) begin
                    t_tick t;
                    t = tick_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_target_increment <= t.inc;
                    i_target_amplitude <= t.amp;
                    if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 5);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and sink stalls
    int unsigned out_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (sample_q.size() == 0) begin
                    report($sformatf("unexpected sample %h", o_output_sample));
                end else begin
                    logic [SMP_W-1:0] want;
                    want = sample_q.pop_front();
                    if (want !== o_output_sample)
                        report($sformatf("output_sample got %h want %h",
                                         o_output_sample, want));
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 5);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG) begin
                $display("wavetable_sine_oscillator regression: fail");
                $finish;
            end
        end
    end

    task automatic add_tick(input logic [INC_W-1:0] inc, input logic [AMP_W-1:0] amp);
        tick_q.push_back('{inc: inc, amp: amp});
    endtask

    task automatic drain();
        while (tick_q.size() > 0 || i_in_valid || sample_q.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_ramp(input logic [RS_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        ramp_len = val;
        inc_now = inc_goal << INC_EXTRA;
        inc_left = 0;
        inc_step = 0;
        gain_now = gain_goal << GAIN_EXTRA;
        gain_left = 0;
        gain_step = 0;
    endtask

    logic [INC_W-1:0] inc_goal_hint = '0;
    logic [AMP_W-1:0] amp_goal_hint = '0;

    // random tick: audio-range increments half the time, else up to half or full range
    task automatic rand_tick();
        logic [INC_W-1:0] inc;
        logic [AMP_W-1:0] amp;
        case ($urandom_range(0, 3))
            0: inc = INC_W'($urandom_range(0, 33554432));
            1: inc = INC_W'($urandom);
            default: inc = INC_W'($urandom_range(0, 1 << 20));
        endcase
        amp = ($urandom_range(0, 2) == 0) ? AMP_W'($urandom)
                                          : AMP_W'($urandom_range(0, 16384));
        if ($urandom_range(0, 3) == 0) begin
            inc = inc_goal_hint;
            amp = amp_goal_hint;
        end
        inc_goal_hint = inc;
        amp_goal_hint = amp;
        add_tick(inc, amp);
    endtask

    initial begin
        logic [RS_W-1:0] ramps [6];
        ramps = '{16'd0, 16'd1, 16'd3, 16'd17, 16'd65535, 16'd250};
        for (int i = 0; i < TSIZE; i++) sine_tab[i] = sine_point(i);
        phase_acc = 0; inc_now = 0; inc_goal = 0; inc_step = 0; inc_left = 0;
        gain_now = 0; gain_goal = 0; gain_step = 0; gain_left = 0;
        ramp_len = RAMP_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset ramp length, extremes, gain above one, fast increments
        add_tick(26'd33554432, 16'hFFFF);
        add_tick(26'd33554432, 16'hFFFF);
        add_tick(26'h3FFFFFF, 16'd16384);
        add_tick(26'd0, 16'd0);
        add_tick(26'd65536, 16'd16384);
        drain();
        set_ramp(16'd0);
        add_tick(26'd65536, 16'hFFFF);
        add_tick(26'd65536, 16'hFFFF);
        add_tick(26'h3FFFFFF, 16'd32768);
        add_tick(26'd1 << 24, 16'd49152);
        add_tick(26'd0, 16'd16384);
        add_tick(26'd12345, 16'd0);
        add_tick(26'h2AAAAAA, 16'h5555);
        add_tick(26'h1555555, 16'hAAAA);
        drain();
        set_ramp(16'd2);
        add_tick(26'd1000, 16'd20000);
        add_tick(26'd1000, 16'd20000);
        add_tick(26'd3, 16'd1);
        add_tick(26'd3, 16'd1);
        add_tick(26'd3, 16'd1);
        // hold the sender until every sample is back
        drain();

        // random phases with different ramp lengths
        foreach (ramps[r]) begin
            set_ramp(ramps[r]);
            repeat (220) rand_tick();
            drain();
        end
        // last stretch without idling
        calm = 1'b1;
        repeat (150) rand_tick();
        drain();

        if (err_cnt == 0) $display("wavetable_sine_oscillator regression: pass");
        else $display("wavetable_sine_oscillator regression: fail");
        $finish;
    end

endmodule
